@@ design/lbm_pkg.sv @@
// Shared types, constants and fixed-point helpers for the bicycle model step.
// Used by every other file in the project; depends on nothing else.
`default_nettype none
package lbm_pkg;

  localparam int unsigned LANES     = 4;
  localparam int unsigned FR_STAGES = 5;
  localparam int unsigned SC_STAGES = 13;
  localparam int unsigned BK_STAGES = 5;

  localparam logic [16:0] STEP_TIME_RST = 17'd6554;

  typedef logic signed [31:0] q16_t;

  typedef struct packed {
    q16_t px;
    q16_t py;
    q16_t head;
    q16_t steer;
    q16_t dtv;
    q16_t g;
    q16_t w;
  } lbm_side_t;

  function automatic q16_t sat32(input logic signed [65:0] v);
    q16_t r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic q16_t qmul(input q16_t a, input q16_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    p = p + 64'sd32768;
    return sat32(66'(p >>> 16));
  endfunction

  function automatic q16_t half_r(input q16_t x);
    logic signed [32:0] t;
    t = 33'(x) + 33'sd1;
    return 32'(t >>> 1);
  endfunction

  function automatic q16_t quarter_r(input q16_t x);
    logic signed [32:0] t;
    t = 33'(x) + 33'sd2;
    return 32'(t >>> 2);
  endfunction

endpackage
`default_nettype wire

@@ design/lbm_sincos.sv @@
// Four-lane pipelined sine/cosine, Q15.16 in, Q1.16 out, side word carried.
// Depends on lbm_pkg.
`default_nettype none
module lbm_sincos
  import lbm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      up_v,
  output logic           up_rdy,
  input  wire q16_t      ang [LANES],
  input  wire lbm_side_t up_side,
  output logic           dn_v,
  input  wire logic      dn_rdy,
  output logic signed [17:0] sn [LANES],
  output logic signed [17:0] cs [LANES],
  output lbm_side_t      dn_side
);

  localparam logic signed [63:0] INV_TWO_PI   = 64'sd683565276;
  localparam logic [63:0]        HALF_PI_FRAC = 64'd2451551556;
  localparam logic [30:0]        ONE_Q30      = 31'h4000_0000;

  localparam logic [5:0] D42 = 6'd42;
  localparam logic [5:0] D56 = 6'd56;
  localparam logic [5:0] D20 = 6'd20;
  localparam logic [5:0] D30 = 6'd30;
  localparam logic [5:0] D6  = 6'd6;
  localparam logic [5:0] D12 = 6'd12;
  localparam logic [5:0] S42 = 6'd37;
  localparam logic [5:0] S56 = 6'd37;
  localparam logic [5:0] S20 = 6'd36;
  localparam logic [5:0] S30 = 6'd36;
  localparam logic [5:0] S6  = 6'd34;
  localparam logic [5:0] S12 = 6'd35;
  localparam logic [31:0] R42 = 32'((64'd1 << 37) / 64'd42);
  localparam logic [31:0] R56 = 32'((64'd1 << 37) / 64'd56);
  localparam logic [31:0] R20 = 32'((64'd1 << 36) / 64'd20);
  localparam logic [31:0] R30 = 32'((64'd1 << 36) / 64'd30);
  localparam logic [31:0] R6  = 32'((64'd1 << 34) / 64'd6);
  localparam logic [31:0] R12 = 32'((64'd1 << 35) / 64'd12);

  localparam logic [1:0] QD_I   = 2'd0;
  localparam logic [1:0] QD_II  = 2'd1;
  localparam logic [1:0] QD_III = 2'd2;

  typedef struct packed {
    logic [31:0] phase;
    logic [2:0]  oct;
    logic [30:0] z;
    logic [31:0] z2;
    logic [31:0] ys;
    logic [31:0] yc;
    logic [31:0] qs;
    logic [31:0] qc;
    logic [30:0] ts;
    logic [30:0] tc;
    logic signed [17:0] sn;
    logic signed [17:0] cs;
  } sc_lane_t;

  typedef struct packed {
    logic signed [17:0] sn;
    logic signed [17:0] cs;
  } sc_pair_t;

  function automatic logic [31:0] sc_phase(input q16_t a);
    logic signed [63:0] p;
    p = 64'(a) * INV_TWO_PI;
    return p[47:16];
  endfunction

  function automatic logic [30:0] sc_z(input logic [31:0] ph);
    logic [29:0] f;
    logic [63:0] p;
    f = {1'b0, ph[28:0]};
    if (ph[29]) begin
      f = 30'h2000_0000 - f;
    end
    p = 64'(f) * HALF_PI_FRAC;
    return 31'(64'(f) + (p >> 32));
  endfunction

  function automatic logic [31:0] mulq30(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    return 32'(p >> 30);
  endfunction

  function automatic logic [31:0] rc_est(input logic [31:0] y, input logic [31:0] m,
                                         input logic [5:0] s);
    logic [63:0] p;
    p = 64'(y) * 64'(m);
    return 32'(p >> s);
  endfunction

  function automatic logic [30:0] rc_term(input logic [31:0] y, input logic [31:0] q0,
                                          input logic [5:0] d);
    logic [37:0] r;
    logic [31:0] q;
    r = 38'(y) - 38'(q0) * 38'(d);
    q = (r >= 38'(d)) ? q0 + 32'd1 : q0;
    return ONE_Q30 - 31'(q);
  endfunction

  function automatic sc_pair_t sc_final(input logic [2:0] oct, input logic [31:0] s32,
                                        input logic [31:0] yc);
    logic [30:0] c;
    logic [30:0] s;
    logic [30:0] sw;
    logic [30:0] cw;
    logic signed [17:0] ms;
    logic signed [17:0] mc;
    sc_pair_t r;
    c = ONE_Q30 - 31'(yc >> 1);
    s = s32[30:0];
    if (oct[0]) begin
      sw = c;
      cw = s;
    end else begin
      sw = s;
      cw = c;
    end
    ms = 18'((32'(sw) + 32'd8192) >> 14);
    mc = 18'((32'(cw) + 32'd8192) >> 14);
    case (oct[2:1])
      QD_I: begin
        r.sn = ms;
        r.cs = mc;
      end
      QD_II: begin
        r.sn = mc;
        r.cs = -ms;
      end
      QD_III: begin
        r.sn = -ms;
        r.cs = -mc;
      end
      default: begin
        r.sn = -mc;
        r.cs = ms;
      end
    endcase
    return r;
  endfunction

  sc_lane_t  st_r   [SC_STAGES][LANES];
  sc_lane_t  st_nxt [SC_STAGES][LANES];
  lbm_side_t sd_r   [SC_STAGES];
  lbm_side_t sd_nxt [SC_STAGES];
  logic [SC_STAGES-1:0] v_r;
  logic [SC_STAGES-1:0] en;
  sc_pair_t  fin [LANES];

  always_comb begin
    en[SC_STAGES-1] = !v_r[SC_STAGES-1] || dn_rdy;
    for (int k = SC_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    sd_nxt[0] = up_side;
    for (int k = 1; k < SC_STAGES; k++) begin
      sd_nxt[k] = sd_r[k-1];
    end
    for (int l = 0; l < LANES; l++) begin
      st_nxt[0][l]       = '0;
      st_nxt[0][l].phase = sc_phase(ang[l]);
      for (int k = 1; k < SC_STAGES; k++) begin
        st_nxt[k][l] = st_r[k-1][l];
      end
      st_nxt[1][l].oct  = st_r[0][l].phase[31:29];
      st_nxt[1][l].z    = sc_z(st_r[0][l].phase);
      st_nxt[2][l].z2   = mulq30(32'(st_r[1][l].z), 32'(st_r[1][l].z));
      st_nxt[3][l].qs   = rc_est(st_r[2][l].z2, R42, S42);
      st_nxt[3][l].qc   = rc_est(st_r[2][l].z2, R56, S56);
      st_nxt[3][l].ys   = st_r[2][l].z2;
      st_nxt[3][l].yc   = st_r[2][l].z2;
      st_nxt[4][l].ts   = rc_term(st_r[3][l].ys, st_r[3][l].qs, D42);
      st_nxt[4][l].tc   = rc_term(st_r[3][l].yc, st_r[3][l].qc, D56);
      st_nxt[5][l].ys   = mulq30(st_r[4][l].z2, 32'(st_r[4][l].ts));
      st_nxt[5][l].yc   = mulq30(st_r[4][l].z2, 32'(st_r[4][l].tc));
      st_nxt[6][l].qs   = rc_est(st_r[5][l].ys, R20, S20);
      st_nxt[6][l].qc   = rc_est(st_r[5][l].yc, R30, S30);
      st_nxt[7][l].ts   = rc_term(st_r[6][l].ys, st_r[6][l].qs, D20);
      st_nxt[7][l].tc   = rc_term(st_r[6][l].yc, st_r[6][l].qc, D30);
      st_nxt[8][l].ys   = mulq30(st_r[7][l].z2, 32'(st_r[7][l].ts));
      st_nxt[8][l].yc   = mulq30(st_r[7][l].z2, 32'(st_r[7][l].tc));
      st_nxt[9][l].qs   = rc_est(st_r[8][l].ys, R6, S6);
      st_nxt[9][l].qc   = rc_est(st_r[8][l].yc, R12, S12);
      st_nxt[10][l].ts  = rc_term(st_r[9][l].ys, st_r[9][l].qs, D6);
      st_nxt[10][l].tc  = rc_term(st_r[9][l].yc, st_r[9][l].qc, D12);
      st_nxt[11][l].ys  = mulq30(32'(st_r[10][l].z), 32'(st_r[10][l].ts));
      st_nxt[11][l].yc  = mulq30(st_r[10][l].z2, 32'(st_r[10][l].tc));
      fin[l] = sc_final(st_r[11][l].oct, st_r[11][l].ys, st_r[11][l].yc);
      st_nxt[12][l].sn  = fin[l].sn;
      st_nxt[12][l].cs  = fin[l].cs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= up_v;
      end
      for (int k = 1; k < SC_STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SC_STAGES; k++) begin
      if (en[k]) begin
        st_r[k] <= st_nxt[k];
        sd_r[k] <= sd_nxt[k];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sn[l] = st_r[SC_STAGES-1][l].sn;
      cs[l] = st_r[SC_STAGES-1][l].cs;
    end
  end

  assign up_rdy  = en[0];
  assign dn_v    = v_r[SC_STAGES-1];
  assign dn_side = sd_r[SC_STAGES-1];

endmodule
`default_nettype wire

@@ design/lateral_bicycle_model_step.sv @@
// Top level of the kinematic bicycle model step: front products, heading
// samples, sine/cosine pipeline and position/Jacobian back end. Uses lbm_pkg, lbm_sincos.
//
// The block takes one request per clock while in_stall is low and returns
// one result per request, in order. Every multiplier is followed by a
// register, and the sine/cosine series runs as a 13-stage pipeline over
// four lanes, one lane per heading sample. A stage that holds no item is
// filled even while later stages are stalled, so requests keep entering
// until the pipeline is full. The step time register is written through
// the cfg_ port, which is always ready; write it only while no request is
// in flight.
`default_nettype none
module lateral_bicycle_model_step
  import lbm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire q16_t        in_pos_x,
  input  wire q16_t        in_pos_y,
  input  wire q16_t        in_heading,
  input  wire q16_t        in_steer_angle,
  input  wire q16_t        in_steer_rate,
  input  wire q16_t        in_ref_speed,
  input  wire q16_t        in_curvature_gain,
  output logic             out_valid,
  input  wire logic        out_stall,
  output q16_t             out_next_x,
  output q16_t             out_next_y,
  output q16_t             out_next_heading,
  output q16_t             out_next_steer,
  output q16_t             out_jac_x_heading,
  output q16_t             out_jac_x_steer,
  output q16_t             out_jac_y_heading,
  output q16_t             out_jac_y_steer,
  output q16_t             out_jac_heading_steer,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [16:0] cfg_step_time
);

  localparam logic signed [36:0] BK_LIM  = 37'sd12884901888;
  localparam logic [19:0]        RC3     = 20'd699051;
  localparam logic [5:0]         SH3     = 6'd21;

  typedef struct packed {
    q16_t px;
    q16_t py;
    q16_t th;
    q16_t dl;
    q16_t om;
    q16_t v;
    q16_t kv;
    q16_t dtv;
    q16_t dt2;
    q16_t dom;
    q16_t w;
    q16_t kv2;
    q16_t a;
    q16_t omw;
    q16_t g;
    q16_t m;
    q16_t h1;
    q16_t h2;
    q16_t h3;
    q16_t nsteer;
  } front_t;

  typedef struct packed {
    lbm_side_t sd;
    logic signed [20:0] sc;
    logic signed [20:0] ss;
    logic signed [17:0] s0;
    logic signed [17:0] c0;
    logic signed [52:0] pxp;
    logic signed [52:0] pyp;
    q16_t jxh;
    q16_t jyh;
    q16_t jxs_p;
    q16_t jys_p;
    q16_t jxs;
    q16_t jys;
    logic [34:0] ux;
    logic [34:0] uy;
    logic [18:0] ax;
    logic [18:0] ay;
    q16_t nx;
    q16_t ny;
  } back_t;

  function automatic logic [34:0] bk_bias(input logic signed [52:0] p);
    logic signed [53:0] t;
    logic signed [36:0] qv;
    logic signed [36:0] qc;
    logic signed [37:0] u;
    t  = 54'(p) + 54'sd196608;
    qv = 37'(t >>> 17);
    if (qv > BK_LIM) begin
      qc = BK_LIM;
    end else if (qv < -BK_LIM) begin
      qc = -BK_LIM;
    end else begin
      qc = qv;
    end
    u = 38'(qc) + 38'(BK_LIM);
    return u[34:0];
  endfunction

  function automatic logic [18:0] div3(input logic [18:0] x);
    logic [39:0] p;
    p = 40'(x) * 40'(RC3);
    return 19'(p >> SH3);
  endfunction

  function automatic q16_t bk_final(input q16_t pos, input logic [34:0] u,
                                    input logic [18:0] a);
    logic [18:0] r;
    logic [18:0] low;
    logic signed [37:0] q;
    r   = u[34:16] - 19'(a * 19'd3);
    low = {1'b0, r[1:0], u[15:0]};
    q   = 38'({a, 16'h0000}) + 38'(div3(low)) - 38'sd4294967296;
    return sat32(66'(pos) + 66'(q));
  endfunction

  logic [16:0] dt_r;
  q16_t        dtq;

  front_t fr_r   [FR_STAGES];
  front_t fr_nxt [FR_STAGES];
  logic [FR_STAGES-1:0] fv_r;
  logic [FR_STAGES-1:0] fen;

  back_t  bk_r   [BK_STAGES];
  back_t  bk_nxt [BK_STAGES];
  logic [BK_STAGES-1:0] bv_r;
  logic [BK_STAGES-1:0] ben;

  logic               sc_up_rdy;
  logic               sc_dn_v;
  q16_t               sc_ang [LANES];
  lbm_side_t          sc_side_in;
  lbm_side_t          sc_side_out;
  logic signed [17:0] sc_sn [LANES];
  logic signed [17:0] sc_cs [LANES];

  assign cfg_ready = 1'b1;
  assign dtq       = {15'b0, dt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= STEP_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      dt_r <= cfg_step_time;
    end
  end

  always_comb begin
    ben[BK_STAGES-1] = !bv_r[BK_STAGES-1] || !out_stall;
    for (int k = BK_STAGES - 2; k >= 0; k--) begin
      ben[k] = !bv_r[k] || ben[k+1];
    end
    fen[FR_STAGES-1] = !fv_r[FR_STAGES-1] || sc_up_rdy;
    for (int k = FR_STAGES - 2; k >= 0; k--) begin
      fen[k] = !fv_r[k] || fen[k+1];
    end
  end

  assign in_stall = !fen[0];

  always_comb begin
    fr_nxt[0]     = '0;
    fr_nxt[0].px  = in_pos_x;
    fr_nxt[0].py  = in_pos_y;
    fr_nxt[0].th  = in_heading;
    fr_nxt[0].dl  = in_steer_angle;
    fr_nxt[0].om  = in_steer_rate;
    fr_nxt[0].v   = in_ref_speed;
    fr_nxt[0].kv  = qmul(in_curvature_gain, in_ref_speed);
    fr_nxt[0].dtv = qmul(dtq, in_ref_speed);
    fr_nxt[0].dt2 = qmul(dtq, dtq);
    fr_nxt[0].dom = qmul(dtq, in_steer_rate);
    for (int k = 1; k < FR_STAGES; k++) begin
      fr_nxt[k] = fr_r[k-1];
    end
    fr_nxt[1].w   = qmul(fr_r[0].kv, dtq);
    fr_nxt[1].kv2 = qmul(fr_r[0].kv, fr_r[0].v);
    fr_nxt[2].a   = qmul(fr_r[1].dl, fr_r[1].w);
    fr_nxt[2].omw = qmul(fr_r[1].om, fr_r[1].w);
    fr_nxt[2].g   = qmul(fr_r[1].dt2, fr_r[1].kv2);
    fr_nxt[3].m   = qmul(fr_r[2].omw, dtq);
    fr_nxt[4].h1  = sat32(66'(fr_r[3].th) + 66'(half_r(fr_r[3].a)));
    fr_nxt[4].h2  = sat32(66'(fr_r[3].th) + 66'(fr_r[3].a) + 66'(half_r(fr_r[3].m)));
    fr_nxt[4].h3  = sat32(66'(fr_r[3].th) + 66'(half_r(fr_r[3].a))
                          + 66'(quarter_r(fr_r[3].m)));
    fr_nxt[4].nsteer = sat32(66'(fr_r[3].dl) + 66'(fr_r[3].dom));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else begin
      if (fen[0]) begin
        fv_r[0] <= in_valid;
      end
      for (int k = 1; k < FR_STAGES; k++) begin
        if (fen[k]) begin
          fv_r[k] <= fv_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < FR_STAGES; k++) begin
      if (fen[k]) begin
        fr_r[k] <= fr_nxt[k];
      end
    end
  end

  always_comb begin
    sc_ang[0]        = fr_r[FR_STAGES-1].th;
    sc_ang[1]        = fr_r[FR_STAGES-1].h1;
    sc_ang[2]        = fr_r[FR_STAGES-1].h2;
    sc_ang[3]        = fr_r[FR_STAGES-1].h3;
    sc_side_in.px    = fr_r[FR_STAGES-1].px;
    sc_side_in.py    = fr_r[FR_STAGES-1].py;
    sc_side_in.head  = fr_r[FR_STAGES-1].h2;
    sc_side_in.steer = fr_r[FR_STAGES-1].nsteer;
    sc_side_in.dtv   = fr_r[FR_STAGES-1].dtv;
    sc_side_in.g     = fr_r[FR_STAGES-1].g;
    sc_side_in.w     = fr_r[FR_STAGES-1].w;
  end

  lbm_sincos u_sincos (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_v    (fv_r[FR_STAGES-1]),
    .up_rdy  (sc_up_rdy),
    .ang     (sc_ang),
    .up_side (sc_side_in),
    .dn_v    (sc_dn_v),
    .dn_rdy  (ben[0]),
    .sn      (sc_sn),
    .cs      (sc_cs),
    .dn_side (sc_side_out)
  );

  always_comb begin
    bk_nxt[0]    = '0;
    bk_nxt[0].sd = sc_side_out;
    bk_nxt[0].s0 = sc_sn[0];
    bk_nxt[0].c0 = sc_cs[0];
    bk_nxt[0].sc = 21'(sc_cs[0]) + (21'(sc_cs[1]) <<< 1) + 21'(sc_cs[2])
                   + (21'(sc_cs[3]) <<< 1);
    bk_nxt[0].ss = 21'(sc_sn[0]) + (21'(sc_sn[1]) <<< 1) + 21'(sc_sn[2])
                   + (21'(sc_sn[3]) <<< 1);
    for (int k = 1; k < BK_STAGES; k++) begin
      bk_nxt[k] = bk_r[k-1];
    end
    bk_nxt[1].pxp   = 53'(bk_r[0].sd.dtv) * 53'(bk_r[0].sc);
    bk_nxt[1].pyp   = 53'(bk_r[0].sd.dtv) * 53'(bk_r[0].ss);
    bk_nxt[1].jxh   = sat32(-66'(qmul(bk_r[0].sd.dtv, 32'(bk_r[0].s0))));
    bk_nxt[1].jyh   = qmul(bk_r[0].sd.dtv, 32'(bk_r[0].c0));
    bk_nxt[1].jxs_p = qmul(bk_r[0].sd.g, 32'(bk_r[0].s0));
    bk_nxt[1].jys_p = qmul(bk_r[0].sd.g, 32'(bk_r[0].c0));
    bk_nxt[2].ux    = bk_bias(bk_r[1].pxp);
    bk_nxt[2].uy    = bk_bias(bk_r[1].pyp);
    bk_nxt[2].jxs   = sat32(-66'(half_r(bk_r[1].jxs_p)));
    bk_nxt[2].jys   = half_r(bk_r[1].jys_p);
    bk_nxt[3].ax    = div3(bk_r[2].ux[34:16]);
    bk_nxt[3].ay    = div3(bk_r[2].uy[34:16]);
    bk_nxt[4].nx    = bk_final(bk_r[3].sd.px, bk_r[3].ux, bk_r[3].ax);
    bk_nxt[4].ny    = bk_final(bk_r[3].sd.py, bk_r[3].uy, bk_r[3].ay);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
    end else begin
      if (ben[0]) begin
        bv_r[0] <= sc_dn_v;
      end
      for (int k = 1; k < BK_STAGES; k++) begin
        if (ben[k]) begin
          bv_r[k] <= bv_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < BK_STAGES; k++) begin
      if (ben[k]) begin
        bk_r[k] <= bk_nxt[k];
      end
    end
  end

  assign out_valid             = bv_r[BK_STAGES-1];
  assign out_next_x            = bk_r[BK_STAGES-1].nx;
  assign out_next_y            = bk_r[BK_STAGES-1].ny;
  assign out_next_heading      = bk_r[BK_STAGES-1].sd.head;
  assign out_next_steer        = bk_r[BK_STAGES-1].sd.steer;
  assign out_jac_x_heading     = bk_r[BK_STAGES-1].jxh;
  assign out_jac_x_steer       = bk_r[BK_STAGES-1].jxs;
  assign out_jac_y_heading     = bk_r[BK_STAGES-1].jyh;
  assign out_jac_y_steer       = bk_r[BK_STAGES-1].jys;
  assign out_jac_heading_steer = bk_r[BK_STAGES-1].sd.w;

  // The input can only be held off when every stage holds a request.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the pipeline has room");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> fv_r[0])
    else $error("accepted request did not enter the first stage");

  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fv_r[FR_STAGES-1] && !sc_up_rdy) |=> fv_r[FR_STAGES-1])
    else $error("front end dropped a request while the sine unit was full");

endmodule
`default_nettype wire

@@ sim/lbm_step_checker.sv @@
// Checker for the bicycle model step: watches the request, result and step time ports,
// predicts every result in fixed point and compares it field by field.
// Depends on lbm_pkg for the Q15.16 port type and the reset step time.
`timescale 1ns / 1ps
module lbm_step_checker
  import lbm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire q16_t        in_pos_x,
  input  wire q16_t        in_pos_y,
  input  wire q16_t        in_heading,
  input  wire q16_t        in_steer_angle,
  input  wire q16_t        in_steer_rate,
  input  wire q16_t        in_ref_speed,
  input  wire q16_t        in_curvature_gain,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire q16_t        out_next_x,
  input  wire q16_t        out_next_y,
  input  wire q16_t        out_next_heading,
  input  wire q16_t        out_next_steer,
  input  wire q16_t        out_jac_x_heading,
  input  wire q16_t        out_jac_x_steer,
  input  wire q16_t        out_jac_y_heading,
  input  wire q16_t        out_jac_y_steer,
  input  wire q16_t        out_jac_heading_steer,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [16:0] cfg_step_time,
  output int               errors,
  output int               pending
);

  typedef logic [8:0][31:0] step_result_t;

  logic [16:0]  dt_shadow;
  step_result_t next_states[$];
  string        field_names[9] = '{"jac_heading_steer", "jac_y_steer", "jac_y_heading",
                                   "jac_x_steer", "jac_x_heading", "next_steer",
                                   "next_heading", "next_y", "next_x"};

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mul_q16(input longint a, input longint b);
    return clamp32((a * b + 64'sd32768) >>> 16);
  endfunction

  function automatic longint halve(input longint x);
    return (x + 1) >>> 1;
  endfunction

  function automatic longint quarter(input longint x);
    return (x + 2) >>> 2;
  endfunction

  function automatic longint div_floor(input longint p, input longint d);
    longint q;
    q = p / d;
    if (p < 0 && q * d != p) q = q - 1;
    return q;
  endfunction

  function automatic longint mag_q16(input bit [63:0] v30, input bit neg);
    longint m;
    m = longint'((v30 + 64'd8192) >> 14);
    return neg ? -m : m;
  endfunction

  function automatic void trig_q16(input longint ang, output longint sn, output longint cs);
    longint    p;
    bit [31:0] ph;
    bit [2:0]  oct;
    bit [63:0] f, z, z2, t, s, c, sw, cw;
    p = ang * 64'sd683565276;
    ph = p[47:16];
    oct = ph[31:29];
    f = {35'd0, ph[28:0]};
    if (oct[0]) f = 64'h2000_0000 - f;
    z = (f * 64'd6746518852) >> 32;
    z2 = (z * z) >> 30;
    t = 64'd1073741824 - z2 / 42;
    t = 64'd1073741824 - ((z2 * t) >> 30) / 20;
    t = 64'd1073741824 - ((z2 * t) >> 30) / 6;
    s = (z * t) >> 30;
    t = 64'd1073741824 - z2 / 56;
    t = 64'd1073741824 - ((z2 * t) >> 30) / 30;
    t = 64'd1073741824 - ((z2 * t) >> 30) / 12;
    t = 64'd1073741824 - ((z2 * t) >> 30) / 2;
    c = t;
    if (oct[0]) begin
      sw = c;
      cw = s;
    end else begin
      sw = s;
      cw = c;
    end
    case (oct[2:1])
      2'd0: begin
        sn = mag_q16(sw, 1'b0);
        cs = mag_q16(cw, 1'b0);
      end
      2'd1: begin
        sn = mag_q16(cw, 1'b0);
        cs = mag_q16(sw, 1'b1);
      end
      2'd2: begin
        sn = mag_q16(sw, 1'b1);
        cs = mag_q16(cw, 1'b1);
      end
      default: begin
        sn = mag_q16(cw, 1'b1);
        cs = mag_q16(sw, 1'b0);
      end
    endcase
  endfunction

  function automatic step_result_t predict_step(input q16_t px, input q16_t py, input q16_t th,
                                                input q16_t dl, input q16_t om, input q16_t v,
                                                input q16_t k, input logic [16:0] dt_reg);
    longint       dt, kv, w, a, m, dtv, dt2, kv2, g, sumc, sums;
    longint       h[4], sn[4], cs[4];
    step_result_t r;
    dt = longint'({47'd0, dt_reg});
    kv = mul_q16(k, v);
    w = mul_q16(kv, dt);
    a = mul_q16(dl, w);
    m = mul_q16(mul_q16(om, w), dt);
    dtv = mul_q16(dt, v);
    h[0] = th;
    h[1] = clamp32(th + halve(a));
    h[2] = clamp32(th + a + halve(m));
    h[3] = clamp32(th + halve(a) + quarter(m));
    for (int i = 0; i < 4; i++) trig_q16(h[i], sn[i], cs[i]);
    sumc = cs[0] + 2 * cs[1] + cs[2] + 2 * cs[3];
    sums = sn[0] + 2 * sn[1] + sn[2] + 2 * sn[3];
    dt2 = mul_q16(dt, dt);
    kv2 = mul_q16(kv, v);
    g = mul_q16(dt2, kv2);
    r[8] = 32'(clamp32(px + div_floor(dtv * sumc + 196608, 393216)));
    r[7] = 32'(clamp32(py + div_floor(dtv * sums + 196608, 393216)));
    r[6] = 32'(h[2]);
    r[5] = 32'(clamp32(dl + mul_q16(dt, om)));
    r[4] = 32'(clamp32(-mul_q16(dtv, sn[0])));
    r[3] = 32'(clamp32(-halve(mul_q16(g, sn[0]))));
    r[2] = 32'(mul_q16(dtv, cs[0]));
    r[1] = 32'(clamp32(halve(mul_q16(g, cs[0]))));
    r[0] = 32'(w);
    return r;
  endfunction

  assign pending = next_states.size();

  always @(posedge clk) begin
    step_result_t got, want;
    if (!rst_n) begin
      dt_shadow <= STEP_TIME_RST;
      next_states.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) dt_shadow <= cfg_step_time;
      if (in_valid && !in_stall)
        next_states.push_back(predict_step(in_pos_x, in_pos_y, in_heading, in_steer_angle,
                                           in_steer_rate, in_ref_speed, in_curvature_gain,
                                           dt_shadow));
      if (out_valid && !out_stall) begin
        got = {out_next_x, out_next_y, out_next_heading, out_next_steer, out_jac_x_heading,
               out_jac_x_steer, out_jac_y_heading, out_jac_y_steer, out_jac_heading_steer};
        if (next_states.size() == 0) begin
          $display("%0t: result with no request outstanding", $time);
          errors <= errors + 1;
        end else begin
          want = next_states.pop_front();
          if (got != want) begin
            for (int i = 0; i < 9; i++)
              if (got[i] != want[i])
                $display("%0t: %s expected %h actual %h", $time, field_names[i],
                         want[i], got[i]);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

@@ sim/lateral_bicycle_model_step_test.sv @@
// Testbench top: drives requests, step time writes and output stalls, and gives
// the verdict. Depends on lbm_pkg, lateral_bicycle_model_step and lbm_step_checker.
`timescale 1ns / 1ps
module lateral_bicycle_model_step_test;
  import lbm_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  q16_t        in_pos_x = '0, in_pos_y = '0, in_heading = '0, in_steer_angle = '0;
  q16_t        in_steer_rate = '0, in_ref_speed = '0, in_curvature_gain = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  q16_t        out_next_x, out_next_y, out_next_heading, out_next_steer;
  q16_t        out_jac_x_heading, out_jac_x_steer, out_jac_y_heading, out_jac_y_steer;
  q16_t        out_jac_heading_steer;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_step_time = '0;
  int          errors, pending;
  int          idle_pct = 0, stall_pct = 0;
  bit          hold_off = 1'b0;

  always #5 clk = ~clk;

  lateral_bicycle_model_step dut (.*);
  lbm_step_checker checker_i (.*);

  always @(posedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    repeat (200) @(posedge clk);
    wait (idle_pct == 0 && stall_pct == 0 && hold_off == 1'b0 && in_valid);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic send_request(input q16_t px, input q16_t py, input q16_t th, input q16_t dl,
                              input q16_t om, input q16_t v, input q16_t k);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_heading <= th;
    in_steer_angle <= dl;
    in_steer_rate <= om;
    in_ref_speed <= v;
    in_curvature_gain <= k;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic set_step_time(input logic [16:0] dt);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_step_time <= dt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random;
    if ($urandom_range(3) == 0) begin
      send_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      send_request($signed($urandom_range(131072000)) - 65536000,
                   $signed($urandom_range(131072000)) - 65536000,
                   $signed($urandom_range(1700000)) - 850000,
                   $signed($urandom_range(80000)) - 40000,
                   $signed($urandom_range(131072)) - 65536,
                   $signed($urandom_range(3000000)) - 400000,
                   $signed($urandom_range(65536)) - 32768);
    end
  endtask

  initial begin
    logic [16:0] dts[6];
    dts = '{17'd1, 17'd65536, 17'd0, 17'd131071, STEP_TIME_RST, 17'd6554};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_request(0, 0, 0, 0, 0, 0, 0);
    send_request(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_request(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_request(32'sh7fffffff, 32'sh80000000, 0, 32'sh7fffffff, 32'sh80000000,
                 32'sh80000000, 32'sh7fffffff);
    send_request(0, 0, 102944, 0, 0, 655360, 6554);
    send_request(0, 0, 205887, 19661, 32768, 655360, 65536);
    send_request(0, 0, -102944, -19661, -32768, 1310720, 32768);
    send_request(0, 0, 308831, 0, 0, -655360, 65536);
    send_request(0, 0, 411775, 13107, 0, 1966080, 65536);
    send_request(0, 0, 51472, 0, 65536, 65536, 65536);
    send_request(100 << 16, -50 << 16, 1000 << 16, 6554, 6554, 20 << 16, 13107);
    send_request(0, 0, -(2000 << 16), 0, 0, 30 << 16, 0);
    send_request(32'sh7fff0000, 32'sh7fff0000, 0, 0, 0, 32'sh7fff0000, 0);
    send_request(32'sh80010000, 32'sh80010000, 205887, 0, 0, 32'sh7fff0000, 0);
    send_request(0, 0, 0, 32'sh7fff0000, 32'sh7fff0000, 32'sh7fff0000, 32'sh7fff0000);
    send_request(0, 0, 0, 65536, 0, 32'sh01000000, 32'sh01000000);
    send_request(1, -1, 1, -1, 1, -1, 1);
    send_request(-1, 1, -1, 1, -1, 1, -1);
    for (int ph = 0; ph < 6; ph++) begin
      set_step_time(ph == 5 ? 17'($urandom_range(65536, 1)) : dts[ph]);
      case (ph % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 53;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 53;
        end
        default: begin
          idle_pct = 29;
          stall_pct = 29;
        end
      endcase
      for (int n = 0; n < 72; n++) send_random();
    end
    in_valid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    wait (pending == 0);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("lateral_bicycle_model_step_test: clean");
    end else begin
      $display("lateral_bicycle_model_step_test: errors");
    end
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("lateral_bicycle_model_step_test: errors");
    $finish;
  end

endmodule
